/* rtl/prq_pkg.sv */
`default_nettype none

package prq_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH   = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    // Fixed field widths on the ports
    localparam int ID_BITS        = 3;
    localparam int ID_COUNT       = 8;
    localparam int PORT_PRIO_BITS = 8;
    localparam int PORT_CNT_BITS  = 4;

    // Operation codes carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // Result status codes carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic execute;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/prq_ctrl.sv */
`default_nettype none

module prq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output prq_pkg::dp_cmd_t     cmd
);

    prq_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    // Take a beat only when idle and the result register is free by next edge
    assign s_tready = (state_reg == prq_pkg::S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = prq_pkg::S_EXEC;
                end
            end
            prq_pkg::S_EXEC:
            begin
                state_next = prq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = prq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: commands and result-valid tracking
    always_comb
    begin
        cmd.load_in    = accept;
        cmd.execute    = (state_reg == prq_pkg::S_EXEC);
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/prq_datapath.sv */
`default_nettype none

module prq_datapath #(
    parameter int QUEUE_DEPTH   = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire prq_pkg::dp_cmd_t cmd,
    input  wire logic             in_mode,
    input  wire logic [prq_pkg::ID_BITS-1:0]        in_task_id,
    input  wire logic [prq_pkg::PORT_PRIO_BITS-1:0] in_task_priority,
    output prq_pkg::status_t                         res_status,
    output logic [prq_pkg::ID_BITS-1:0]              res_popped_id,
    output logic [prq_pkg::PORT_PRIO_BITS-1:0]       res_popped_priority,
    output logic [prq_pkg::PORT_CNT_BITS-1:0]        res_queue_count
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int IDB      = prq_pkg::ID_BITS;
    localparam int PPB      = prq_pkg::PORT_PRIO_BITS;
    localparam int PCB      = prq_pkg::PORT_CNT_BITS;

    // Captured operation
    logic                     op_mode_reg;
    logic [IDB-1:0]           op_id_reg;
    logic [PRIORITY_BITS-1:0] op_prio_reg;

    // Cell chain, head at cell 0
    logic [IDB-1:0]           slot_id_reg       [QUEUE_DEPTH];
    logic [IDB-1:0]           slot_id_next      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_priority_reg [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_priority_next[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   slot_valid_reg, slot_valid_next;
    logic [prq_pkg::ID_COUNT-1:0] id_queued_reg, id_queued_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;

    // Result register
    prq_pkg::status_t         res_status_reg, res_status_next;
    logic [IDB-1:0]           res_id_reg, res_id_next;
    logic [PRIORITY_BITS-1:0] res_prio_reg, res_prio_next;
    logic [CNT_BITS-1:0]      res_cnt_reg;

    // Neighbor views of the chain
    logic [IDB-1:0]           up_id  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] up_prio[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   up_valid;
    logic [IDB-1:0]           dn_id  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] dn_prio[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   dn_valid;

    logic [QUEUE_DEPTH-1:0]   le;
    logic [QUEUE_DEPTH:0]     le_ext;
    logic                     ins_ok, pop_ok;
    logic [PRIORITY_BITS+PPB-1:0] prio_in_wide;
    logic [PRIORITY_BITS+PPB-1:0] prio_out_wide;
    logic [CNT_BITS+PCB-1:0]      cnt_out_wide;

    // Keep only the low PRIORITY_BITS of the incoming priority
    assign prio_in_wide = {{PRIORITY_BITS{1'b0}}, in_task_priority};

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_mode_reg <= in_mode;
            op_id_reg   <= in_task_id;
            op_prio_reg <= prio_in_wide[PRIORITY_BITS-1:0];
        end
    end

    // Per-cell compare and neighbor taps
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            le[k] = slot_valid_reg[k] && (slot_priority_reg[k] <= op_prio_reg);
        end
        le_ext = {le, 1'b1};

        up_id[0]    = '0;
        up_prio[0]  = '0;
        up_valid[0] = 1'b0;
        for (int k = 1; k < QUEUE_DEPTH; k++)
        begin
            up_id[k]    = slot_id_reg[k-1];
            up_prio[k]  = slot_priority_reg[k-1];
            up_valid[k] = slot_valid_reg[k-1];
        end

        dn_id[QUEUE_DEPTH-1]    = '0;
        dn_prio[QUEUE_DEPTH-1]  = '0;
        dn_valid[QUEUE_DEPTH-1] = 1'b0;
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            dn_id[k]    = slot_id_reg[k+1];
            dn_prio[k]  = slot_priority_reg[k+1];
            dn_valid[k] = slot_valid_reg[k+1];
        end
    end

    assign ins_ok = (op_mode_reg == prq_pkg::MODE_INSERT) && !id_queued_reg[op_id_reg]
                    && (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_ok = (op_mode_reg == prq_pkg::MODE_POP) && (count_reg != '0);

    // Chain update: hold, insert at the first cell past the lower-or-equal run, or shift
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        id_queued_next  = id_queued_reg;
        count_next      = count_reg;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            slot_id_next[k]       = slot_id_reg[k];
            slot_priority_next[k] = slot_priority_reg[k];
            if (ins_ok && !le[k])
            begin
                if (le_ext[k])
                begin
                    slot_id_next[k]       = op_id_reg;
                    slot_priority_next[k] = op_prio_reg;
                    slot_valid_next[k]    = 1'b1;
                end
                else
                begin
                    slot_id_next[k]       = up_id[k];
                    slot_priority_next[k] = up_prio[k];
                    slot_valid_next[k]    = up_valid[k];
                end
            end
            else if (pop_ok)
            begin
                slot_id_next[k]       = dn_id[k];
                slot_priority_next[k] = dn_prio[k];
                slot_valid_next[k]    = dn_valid[k];
            end
        end

        res_status_next = prq_pkg::ST_OK;
        res_id_next     = '0;
        res_prio_next   = '0;
        if (ins_ok)
        begin
            id_queued_next[op_id_reg] = 1'b1;
            count_next                = count_reg + CNT_BITS'(1);
        end
        else if (pop_ok)
        begin
            id_queued_next[slot_id_reg[0]] = 1'b0;
            count_next                     = count_reg - CNT_BITS'(1);
            res_id_next                    = slot_id_reg[0];
            res_prio_next                  = slot_priority_reg[0];
        end
        else if (op_mode_reg == prq_pkg::MODE_POP)
        begin
            res_status_next = prq_pkg::ST_EMPTY;
        end
        else
        begin
            res_status_next = prq_pkg::ST_REJECT;
        end
    end

    // Cell contents and results carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                slot_id_reg[k]       <= slot_id_next[k];
                slot_priority_reg[k] <= slot_priority_next[k];
            end
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_prio_reg   <= res_prio_next;
            res_cnt_reg    <= count_next;
        end
    end

    // Occupancy state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            id_queued_reg  <= '0;
            count_reg      <= '0;
        end
        else if (cmd.execute)
        begin
            slot_valid_reg <= slot_valid_next;
            id_queued_reg  <= id_queued_next;
            count_reg      <= count_next;
        end
    end

    // Fit results to the port widths
    assign prio_out_wide       = {{PPB{1'b0}}, res_prio_reg};
    assign cnt_out_wide        = {{PCB{1'b0}}, res_cnt_reg};
    assign res_status          = res_status_reg;
    assign res_popped_id       = res_id_reg;
    assign res_popped_priority = prio_out_wide[PPB-1:0];
    assign res_queue_count     = cnt_out_wide[PCB-1:0];

endmodule

`default_nettype wire

/* rtl/priority_ready_queue_unit.sv */
// Flow: an accepted beat is captured in the operation registers, then the cell
// chain and the result register update in S_EXEC and the result beat is presented.
// No new item is taken during the S_EXEC update; the next item is taken while the
// previous result drains.
// Reset: rst_n is asynchronous, active low; the queue comes up empty with no
// task ids queued and no result pending.
`default_nettype none

module priority_ready_queue_unit #(
    parameter int QUEUE_DEPTH   = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [2:0] task_id, [10:3] task_priority, rest zero
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [2:0] popped_id, [10:3] popped_priority,
                                        // [14:11] queue_count, [15] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    prq_pkg::dp_cmd_t cmd;
    prq_pkg::status_t res_status;
    logic [prq_pkg::ID_BITS-1:0]        res_popped_id;
    logic [prq_pkg::PORT_PRIO_BITS-1:0] res_popped_priority;
    logic [prq_pkg::PORT_CNT_BITS-1:0]  res_queue_count;

    prq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    prq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .in_mode             (s_tuser),
        .in_task_id          (s_tdata[2:0]),
        .in_task_priority    (s_tdata[10:3]),
        .res_status          (res_status),
        .res_popped_id       (res_popped_id),
        .res_popped_priority (res_popped_priority),
        .res_queue_count     (res_queue_count)
    );

    // Pack the result beat
    assign m_tdata = {1'b0, res_queue_count, res_popped_priority, res_popped_id};
    assign m_tuser = res_status;

endmodule

`default_nettype wire
